### sv/clmf_pkg.sv
// Shared constants, codes and types for the content-length message framer.
// No dependencies; imported by every module of the framer.
package clmf_pkg;

    // Command codes on the opcode field
    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Characters of interest
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Key length and line position ceiling
    localparam logic [4:0] KEY_LEN = 5'd14;
    localparam logic [4:0] POS_MAX = 5'd31;

    localparam int COUNT_BITS = 32;

    // Header status handed from the parser to the body stage
    typedef struct packed {
        logic done_cur;
        logic done_next;
    } t_hdr_status;

    // Text of the "Content-Length" key, one character per index
    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h43; // C
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h4C; // L
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

endpackage

### sv/clmf_hdr.sv
// Header line parser: line tracking, key match and atoi-style length value.
// Depends on clmf_pkg.
module clmf_hdr import clmf_pkg::*; #(
    parameter int LENGTH_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic                   i_opcode,
    input  logic [7:0]             i_data_byte,
    output t_hdr_status            o_status,
    output logic [LENGTH_BITS-1:0] o_length_next
);

    typedef enum logic [1:0] {
        PH_SKIP = 2'd0,
        PH_NUM  = 2'd1,
        PH_END  = 2'd2
    } t_phase;

    logic                   r_done,    n_done;
    logic [4:0]             r_pos,     n_pos;
    logic                   r_prev_cr, n_prev_cr;
    logic                   r_key_ok,  n_key_ok;
    logic                   r_in_val,  n_in_val;
    t_phase                 r_phase,   n_phase;
    logic                   r_neg,     n_neg;
    logic [LENGTH_BITS-1:0] r_accum,   n_accum;
    logic [LENGTH_BITS-1:0] r_length,  n_length;

    logic [LENGTH_BITS+3:0] times_ten;
    logic [LENGTH_BITS-1:0] accum_sat;
    logic                   is_digit;
    logic [7:0]             digit_val;

    // Multiply by ten with shifts, saturate at all ones
    assign is_digit  = (i_data_byte >= CH_ZERO) && (i_data_byte <= CH_NINE);
    assign digit_val = i_data_byte - CH_ZERO;
    assign times_ten = ({4'b0, r_accum} << 3) + ({4'b0, r_accum} << 1)
                     + (LENGTH_BITS+4)'(digit_val[3:0]);
    assign accum_sat = (times_ten[LENGTH_BITS+3:LENGTH_BITS] != 4'd0)
                     ? {LENGTH_BITS{1'b1}} : times_ten[LENGTH_BITS-1:0];

    always_comb begin
        n_done    = r_done;
        n_pos     = r_pos;
        n_prev_cr = r_prev_cr;
        n_key_ok  = r_key_ok;
        n_in_val  = r_in_val;
        n_phase   = r_phase;
        n_neg     = r_neg;
        n_accum   = r_accum;
        n_length  = r_length;
        if (i_opcode == OP_CLEAR) begin
            n_done    = 1'b0;
            n_pos     = 5'd0;
            n_prev_cr = 1'b0;
            n_key_ok  = 1'b1;
            n_in_val  = 1'b0;
            n_phase   = PH_SKIP;
            n_neg     = 1'b0;
            n_accum   = '0;
            n_length  = '0;
        end else if (!r_done) begin
            if (r_prev_cr && i_data_byte == CH_LF) begin
                // end of line: blank line closes the header
                if (r_pos == 5'd1) begin
                    n_done = 1'b1;
                end else if (r_in_val) begin
                    n_length = r_neg ? '0 : r_accum;
                end
                n_pos     = 5'd0;
                n_prev_cr = 1'b0;
                n_key_ok  = 1'b1;
                n_in_val  = 1'b0;
                n_phase   = PH_SKIP;
                n_neg     = 1'b0;
                n_accum   = '0;
            end else begin
                if (r_in_val) begin
                    if (r_phase == PH_END) begin
                        // number already ended, hold
                    end else if (is_digit) begin
                        n_accum = accum_sat;
                        n_phase = PH_NUM;
                    end else if (r_phase == PH_SKIP && is_space(i_data_byte)) begin
                        // keep skipping leading whitespace
                    end else if (r_phase == PH_SKIP &&
                                 (i_data_byte == CH_PLUS || i_data_byte == CH_MINUS)) begin
                        n_neg   = (i_data_byte == CH_MINUS);
                        n_phase = PH_NUM;
                    end else begin
                        n_phase = PH_END;
                    end
                end else if (r_key_ok) begin
                    if (i_data_byte == CH_COLON) begin
                        n_in_val = (r_pos == KEY_LEN);
                        n_key_ok = 1'b0;
                    end else if (r_pos >= KEY_LEN || i_data_byte != key_char(r_pos[3:0])) begin
                        n_key_ok = 1'b0;
                    end
                end
                n_prev_cr = (i_data_byte == CH_CR);
                if (r_pos < POS_MAX) begin
                    n_pos = r_pos + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done    <= 1'b0;
            r_pos     <= 5'd0;
            r_prev_cr <= 1'b0;
            r_key_ok  <= 1'b1;
            r_in_val  <= 1'b0;
            r_phase   <= PH_SKIP;
            r_neg     <= 1'b0;
            r_accum   <= '0;
            r_length  <= '0;
        end else if (i_accept) begin
            r_done    <= n_done;
            r_pos     <= n_pos;
            r_prev_cr <= n_prev_cr;
            r_key_ok  <= n_key_ok;
            r_in_val  <= n_in_val;
            r_phase   <= n_phase;
            r_neg     <= n_neg;
            r_accum   <= n_accum;
            r_length  <= n_length;
        end
    end

    assign o_status.done_cur  = r_done;
    assign o_status.done_next = n_done;
    assign o_length_next      = n_length;

endmodule

### sv/clmf_body.sv
// Body stage: body byte pass-through, saturating body counter, ready compare.
// Depends on clmf_pkg.
module clmf_body import clmf_pkg::*; #(
    parameter int LENGTH_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic                   i_opcode,
    input  logic [7:0]             i_data_byte,
    input  t_hdr_status            i_status,
    input  logic [LENGTH_BITS-1:0] i_length_next,
    output logic                   o_body_valid,
    output logic [7:0]             o_body_byte,
    output logic [COUNT_BITS-1:0]  o_count_next,
    output logic                   o_ready_next
);

    localparam int CMP_BITS = (LENGTH_BITS > COUNT_BITS) ? LENGTH_BITS : COUNT_BITS;

    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [CMP_BITS-1:0]   count_ext, length_ext;

    always_comb begin
        n_count      = r_count;
        o_body_valid = 1'b0;
        if (i_opcode == OP_CLEAR) begin
            n_count = '0;
        end else if (i_status.done_cur) begin
            o_body_valid = 1'b1;
            if (r_count != {COUNT_BITS{1'b1}}) begin
                n_count = r_count + COUNT_BITS'(1);
            end
        end
    end

    assign o_body_byte  = o_body_valid ? i_data_byte : 8'd0;
    assign count_ext    = CMP_BITS'(n_count);
    assign length_ext   = CMP_BITS'(i_length_next);
    assign o_ready_next = i_status.done_next && (count_ext >= length_ext);
    assign o_count_next = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_accept) begin
            r_count <= n_count;
        end
    end

endmodule

### sv/content_length_message_framer_core.sv
// A result is registered as its transaction is taken and shows on the outputs the cycle after.
// Throughput: one transaction per cycle; the only hold-off is a stalled, full output register.
// Reset (i_rst_n low, synchronous): header state, length, body count and output valid clear.
// A clear command returns the same state in-band and yields one result with body_valid low.
// Depends on clmf_pkg, clmf_hdr and clmf_body.
module content_length_message_framer_core import clmf_pkg::*; #(
    parameter int LENGTH_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [7:0]  i_data_byte,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_body_valid,
    output logic [7:0]  o_body_byte,
    output logic        o_header_done,
    output logic        o_message_ready,
    output logic [31:0] o_content_length,
    output logic [31:0] o_body_count
);

    localparam int EXT_BITS = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;

    logic                   accept;
    t_hdr_status            hdr_status;
    logic [LENGTH_BITS-1:0] length_next;
    logic [EXT_BITS-1:0]    length_ext;
    logic                   body_valid;
    logic [7:0]             body_byte;
    logic [COUNT_BITS-1:0]  count_next;
    logic                   ready_next;

    logic        r_out_valid;
    logic        r_body_valid;
    logic [7:0]  r_body_byte;
    logic        r_header_done;
    logic        r_message_ready;
    logic [31:0] r_content_length;
    logic [31:0] r_body_count;

    // Stall the input only while a result sits in the output register and is held
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    // Header parser: all line state advances on each accepted transaction
    clmf_hdr #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_hdr (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_opcode      (i_opcode),
        .i_data_byte   (i_data_byte),
        .o_status      (hdr_status),
        .o_length_next (length_next)
    );

    // Body stage: pass body bytes, count them, compare against the length
    clmf_body #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_body (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_opcode      (i_opcode),
        .i_data_byte   (i_data_byte),
        .i_status      (hdr_status),
        .i_length_next (length_next),
        .o_body_valid  (body_valid),
        .o_body_byte   (body_byte),
        .o_count_next  (count_next),
        .o_ready_next  (ready_next)
    );

    // Report the low 32 bits of the length, zero-extended when narrower
    assign length_ext = EXT_BITS'(length_next);

    // Output register: load on accept, drop valid once the result is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload needs no reset; hold while stalled
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_body_valid     <= body_valid;
            r_body_byte      <= body_byte;
            r_header_done    <= hdr_status.done_next;
            r_message_ready  <= ready_next;
            r_content_length <= length_ext[31:0];
            r_body_count     <= count_next;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_body_valid     = r_body_valid;
    assign o_body_byte      = r_body_byte;
    assign o_header_done    = r_header_done;
    assign o_message_ready  = r_message_ready;
    assign o_content_length = r_content_length;
    assign o_body_count     = r_body_count;

endmodule

### dv/tb_content_length_message_framer_core.sv
// Self-checking bench for content_length_message_framer_core: streams of framed messages go in,
// and each result is checked against a cycle-free model of the framer kept in this file.
// Depends on clmf_pkg and the framer RTL (clmf_hdr, clmf_body, top level).
module tb_content_length_message_framer_core;
    import clmf_pkg::*;

    localparam int          LEN_BITS    = 32;
    localparam logic [63:0] LEN_LIMIT   = (64'd1 << LEN_BITS) - 64'd1;
    localparam int          ITEM_TARGET = 900;
    localparam int          MAX_PRINTS  = 50;

    // Where the number after the colon stands while it is being read
    typedef enum logic [1:0] {
        VAL_SKIP_WS,
        VAL_IN_NUMBER,
        VAL_ENDED
    } t_value_phase;

    typedef struct packed {
        logic        body_valid;
        logic [7:0]  body_byte;
        logic        header_done;
        logic        message_ready;
        logic [31:0] content_length;
        logic [31:0] body_count;
    } t_frame_result;

    // One input transaction; drain holds it back until every expected result is in
    typedef struct packed {
        logic       op;
        logic [7:0] data;
        logic       drain;
    } t_stream_item;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        i_opcode    = OP_PUSH;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_body_valid;
    logic [7:0]  o_body_byte;
    logic        o_header_done;
    logic        o_message_ready;
    logic [31:0] o_content_length;
    logic [31:0] o_body_count;

    content_length_message_framer_core #(
        .LENGTH_BITS(LEN_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_data_byte     (i_data_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_body_valid    (o_body_valid),
        .o_body_byte     (o_body_byte),
        .o_header_done   (o_header_done),
        .o_message_ready (o_message_ready),
        .o_content_length(o_content_length),
        .o_body_count    (o_body_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_stream_item  byte_stream_q[$];     // transactions not yet offered
    t_frame_result frame_results_due[$]; // predicted results, oldest first

    int    n_mismatch = 0;
    int    n_sent     = 0;
    int    n_taken    = 0;
    int    gap_left   = 0;
    int    stall_left = 0;
    int    cyc_cnt    = 0;
    int    hold_left  = 0;
    bit    drain_flag = 1'b0;
    string crlf;
    string key_text   = "Content-Length";
    byte   ws_set[6]  = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    string other_keys[7] = '{"Content-Type", "content-length", "Content-Lengt",
                             "Content-Lengthh", "Content-Length ", "X", ""};

    // ------------------------------------------------------------------
    // Framer model state
    // ------------------------------------------------------------------
    logic         hdr_done;
    logic [4:0]   line_pos;  // bytes in the current line, saturating
    logic         saw_cr;
    logic         key_ok;    // line still spells the length key so far
    logic         in_val;    // past the colon of a length line
    t_value_phase val_phase;
    logic         val_neg;
    logic [63:0]  val_acc;
    logic [63:0]  len_val;
    logic [31:0]  body_cnt;

    task automatic restart_line();
        line_pos  = '0;
        saw_cr    = 1'b0;
        key_ok    = 1'b1;
        in_val    = 1'b0;
        val_phase = VAL_SKIP_WS;
        val_neg   = 1'b0;
        val_acc   = '0;
    endtask

    task automatic clear_framer();
        hdr_done = 1'b0;
        len_val  = '0;
        body_cnt = '0;
        restart_line();
    endtask

    // Apply one accepted transaction to the model and queue the result it yields
    task automatic advance_framer(input logic op, input logic [7:0] b);
        t_frame_result r;
        logic [63:0]   digit;
        r     = '0;
        digit = {56'd0, b - CH_ZERO};
        if (op == OP_CLEAR) begin
            clear_framer();
        end else if (hdr_done) begin
            // body: pass the byte out and count it, saturating
            r.body_valid = 1'b1;
            r.body_byte  = b;
            if (body_cnt != '1)
                body_cnt++;
        end else if (saw_cr && b == CH_LF) begin
            // end of line: a bare CR LF ends the header, a length line commits its value
            if (line_pos == 5'd1)
                hdr_done = 1'b1;
            else if (in_val)
                len_val = val_neg ? 64'd0 : val_acc;
            restart_line();
        end else begin
            if (in_val) begin
                if (val_phase != VAL_ENDED) begin
                    if (b >= CH_ZERO && b <= CH_NINE) begin
                        if (val_acc > (LEN_LIMIT - digit) / 64'd10)
                            val_acc = LEN_LIMIT;
                        else
                            val_acc = val_acc * 64'd10 + digit;
                        val_phase = VAL_IN_NUMBER;
                    end else if (val_phase == VAL_SKIP_WS &&
                                 (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))) begin
                        val_phase = VAL_SKIP_WS;
                    end else if (val_phase == VAL_SKIP_WS && (b == CH_PLUS || b == CH_MINUS)) begin
                        val_neg   = (b == CH_MINUS);
                        val_phase = VAL_IN_NUMBER;
                    end else begin
                        val_phase = VAL_ENDED;
                    end
                end
            end else if (key_ok) begin
                if (b == CH_COLON) begin
                    in_val = (line_pos == KEY_LEN);
                    key_ok = 1'b0;
                end else if (line_pos >= KEY_LEN || b != key_text[line_pos]) begin
                    key_ok = 1'b0;
                end
            end
            saw_cr = (b == CH_CR);
            if (line_pos != POS_MAX)
                line_pos++;
        end
        r.header_done    = hdr_done;
        r.message_ready  = hdr_done && ({32'd0, body_cnt} >= len_val);
        r.content_length = len_val[31:0];
        r.body_count     = body_cnt;
        frame_results_due = {frame_results_due, r};
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(input logic op, input logic [7:0] b);
        t_stream_item it;
        it.op      = op;
        it.data    = b;
        it.drain   = drain_flag;
        drain_flag = 1'b0;
        byte_stream_q = {byte_stream_q, it};
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_item(OP_PUSH, s[i]);
    endtask

    function automatic string rand_word(input int n);
        string w;
        w = "";
        repeat (n) w = $sformatf("%s%c", w, 8'($urandom_range(97, 122)));
        return w;
    endfunction

    task automatic report_mismatch(input string what);
        n_mismatch++;
        if (n_mismatch <= MAX_PRINTS)
            $display("[%0t] framer check failed: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Driver: offer queued transactions, predict each one as it is taken
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : driver
        t_stream_item nxt;
        logic         nxt_valid;
        if (!i_rst_n) begin
            clear_framer();
            frame_results_due.delete();
            gap_left = 0;
            n_sent   = 0;
            i_in_valid  <= 1'b0;
            i_opcode    <= OP_PUSH;
            i_data_byte <= 8'h00;
        end else begin
            nxt_valid = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                advance_framer(i_opcode, i_data_byte);
                n_sent++;
                nxt_valid = 1'b0;
                // draw the gap before the next transaction; every fourth stretch runs flat out
                gap_left = ((n_sent / 100) % 4 == 2) ? 0 : $urandom_range(0, 8);
            end
            if (!nxt_valid) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (byte_stream_q.size() != 0 &&
                             !(byte_stream_q[0].drain && frame_results_due.size() != 0)) begin
                    // hold a drain-marked transaction until the block has emptied
                    nxt = byte_stream_q.pop_front();
                    i_opcode    <= nxt.op;
                    i_data_byte <= nxt.data;
                    nxt_valid = 1'b1;
                end
            end
            // one assignment per edge: valid stays high across back-to-back transactions
            i_in_valid <= nxt_valid;
        end
    end

    // ------------------------------------------------------------------
    // Long receiver hold-off, timed in its own process
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cyc_cnt   <= 0;
            hold_left <= 0;
        end else begin
            cyc_cnt <= cyc_cnt + 1;
            if (cyc_cnt == 1500 || cyc_cnt == 3000)
                hold_left <= 250;
            else if (hold_left != 0)
                hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: take results, compare against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_frame_result want;
        logic          nxt_stall;
        if (!i_rst_n) begin
            stall_left = 0;
            n_taken    = 0;
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                n_taken++;
                if (frame_results_due.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              n_taken));
                end else begin
                    want = frame_results_due.pop_front();
                    if (o_body_valid !== want.body_valid)
                        report_mismatch($sformatf("result %0d body_valid got %0b want %0b",
                                                  n_taken, o_body_valid, want.body_valid));
                    if (o_body_byte !== want.body_byte)
                        report_mismatch($sformatf("result %0d body_byte got %h want %h",
                                                  n_taken, o_body_byte, want.body_byte));
                    if (o_header_done !== want.header_done)
                        report_mismatch($sformatf("result %0d header_done got %0b want %0b",
                                                  n_taken, o_header_done, want.header_done));
                    if (o_message_ready !== want.message_ready)
                        report_mismatch($sformatf("result %0d message_ready got %0b want %0b",
                                                  n_taken, o_message_ready, want.message_ready));
                    if (o_content_length !== want.content_length)
                        report_mismatch($sformatf("result %0d content_length got %0d want %0d",
                                                  n_taken, o_content_length,
                                                  want.content_length));
                    if (o_body_count !== want.body_count)
                        report_mismatch($sformatf("result %0d body_count got %0d want %0d",
                                                  n_taken, o_body_count, want.body_count));
                end
                stall_left = ((n_taken / 100) % 4 == 1) ? 0 : $urandom_range(0, 8);
            end
            nxt_stall = 1'b0;
            if (stall_left != 0) begin
                stall_left--;
                nxt_stall = 1'b1;
            end
            i_out_stall <= nxt_stall || (hold_left != 0);
        end
    end

    // ------------------------------------------------------------------
    // Build the transaction stream, release reset, wait for the end
    // ------------------------------------------------------------------
    initial begin : stimulus_and_control
        int    msg_no;
        int    n_lines;
        int    body_len;
        int    len_pick;
        string s;
        crlf = $sformatf("%c%c", CH_CR, CH_LF);

        // Directed: empty header right away, body bytes at both extremes, negative length
        push_item(OP_CLEAR, 8'hA5);
        push_text(crlf);
        push_item(OP_PUSH, 8'h00);
        push_item(OP_PUSH, 8'hFF);
        push_item(OP_CLEAR, 8'h00);
        push_text({"Content-Length:-7", crlf, crlf});
        push_item(OP_CLEAR, 8'hFF);
        drain_flag = 1'b1;

        // Random: mostly well-formed messages with varied header lines, some noise
        msg_no = 0;
        while (byte_stream_q.size() < ITEM_TARGET) begin
            if (msg_no % 6 == 5)
                drain_flag = 1'b1;
            msg_no++;
            if ($urandom_range(0, 9) == 0) begin
                // noise: random bytes and occasional clears, then a clear to resync
                repeat ($urandom_range(4, 16))
                    push_item(($urandom_range(0, 7) == 0) ? OP_CLEAR : OP_PUSH,
                              8'($urandom_range(0, 255)));
                push_item(OP_CLEAR, 8'($urandom_range(0, 255)));
                continue;
            end
            body_len = $urandom_range(0, 10);
            n_lines  = $urandom_range(0, 3);
            for (int k = 0; k <= n_lines; k++) begin
                len_pick = $urandom_range(0, 20);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        // length line: whitespace, sign, digits, maybe trailing junk
                        s = "Content-Length:";
                        repeat ($urandom_range(0, 2))
                            s = $sformatf("%s%c", s, ws_set[$urandom_range(0, 5)]);
                        case ($urandom_range(0, 9))
                            0:       s = {s, "+"};
                            1:       s = {s, "-"};
                            default: ;
                        endcase
                        case ($urandom_range(0, 19))
                            0: repeat ($urandom_range(10, 20))
                                   s = $sformatf("%s%0d", s, $urandom_range(0, 9));
                            1: ;  // no digits at all
                            2: s = {s, "4294967295"};
                            3: s = {s, "4294967296"};
                            default: begin
                                s = $sformatf("%s%0d", s, len_pick);
                                body_len = len_pick + (($urandom_range(0, 3) == 0) ? 1 : 0);
                            end
                        endcase
                        if ($urandom_range(0, 4) == 0)
                            s = {s, ($urandom_range(0, 1) != 0) ? " 9" : "z3"};
                    end
                    4, 5: s = $sformatf("%s: %0d", other_keys[$urandom_range(0, 6)],
                                        $urandom_range(0, 99));
                    6:    s = rand_word($urandom_range(1, 10));
                    7: begin
                        // lone CR or LF inside a line
                        case ($urandom_range(0, 3))
                            0: begin
                                s = $sformatf("Content-Length:%c%0d", CH_CR, len_pick);
                                body_len = len_pick;
                            end
                            1:       s = $sformatf("Content-%cLength: 3", CH_CR);
                            2:       s = {rand_word(2), "\n", rand_word(2)};
                            default: s = $sformatf("%c", CH_CR);
                        endcase
                    end
                    default: begin
                        // lines past the position ceiling
                        if ($urandom_range(0, 1) != 0) begin
                            s = rand_word($urandom_range(30, 40));
                        end else begin
                            s = "Content-Length:";
                            repeat (20) s = {s, " "};
                            s = $sformatf("%s%0d", s, len_pick);
                            body_len = len_pick;
                        end
                    end
                endcase
                push_text({s, crlf});
            end
            if ($urandom_range(0, 6) == 0) begin
                // broken message: cut off inside the header
                push_text(rand_word($urandom_range(1, 6)));
            end else begin
                push_text(crlf);
                repeat (body_len) push_item(OP_PUSH, 8'($urandom_range(0, 255)));
            end
            push_item(OP_CLEAR, 8'($urandom_range(0, 255)));
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sample on the falling edge so the clocked processes have settled
        do @(negedge i_clk);
        while (byte_stream_q.size() != 0 || i_in_valid || frame_results_due.size() != 0);
        repeat (8) @(negedge i_clk);

        if (n_mismatch == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog far beyond the slowest legal run
    initial begin
        #3000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
